// File: hw/rtl/wia_pkg.sv
// ----------------------------------------------------------------------------
// wia_pkg
// Shared types and constants of the window interval averager: operation
// codes, field widths, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package wia_pkg;

  localparam int OpW       = 2;
  localparam int TimeW     = 48;
  localparam int IntervalW = 32;
  localparam int SumW      = 36;
  localparam int FillW     = 5;
  localparam int MeanW     = 32;
  localparam int WinLenW   = 5;

  localparam int RingDepthDef = 16;
  localparam logic [WinLenW-1:0] WinLenRst = WinLenW'(16);

  // Operation codes carried by the op field.
  localparam logic [OpW-1:0] OP_RECORD = 2'd0;
  localparam logic [OpW-1:0] OP_START  = 2'd1;
  localparam logic [OpW-1:0] OP_RESET  = 2'd2;

  // Restoring divide: one quotient bit per step over the whole sum.
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FETCH  = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  typedef struct packed {
    logic capture;
    logic cfg_write;
    logic fetch;
    logic commit;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_record;
    logic div_last;
  } sts_t;

endpackage

// File: hw/rtl/wia_ram.sv
// ----------------------------------------------------------------------------
// wia_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wia_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/wia_ctrl.sv
// ----------------------------------------------------------------------------
// wia_ctrl
// Sequencing state machine: takes one beat at a time, steps the datapath
// through fetch, for a record also update and divide, and loads the result.
// ----------------------------------------------------------------------------
module wia_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  wia_pkg::sts_t sts_i,
  output wia_pkg::cmd_t cmd_o
);

  wia_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  // A pending register write goes first when both arrive together.
  assign cfg_ready_o = (state_q == wia_pkg::ST_IDLE);
  assign in_ready_o  = (state_q == wia_pkg::ST_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      wia_pkg::ST_IDLE: begin
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = wia_pkg::ST_FETCH;
        end
      end
      wia_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = sts_i.is_record ? wia_pkg::ST_UPDATE : wia_pkg::ST_DONE;
      end
      wia_pkg::ST_UPDATE: begin
        cmd_o.commit = 1'b1;
        state_d      = wia_pkg::ST_DIVIDE;
      end
      wia_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = wia_pkg::ST_DONE;
        end
      end
      wia_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = wia_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wia_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wia_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/wia_dpath.sv
// ----------------------------------------------------------------------------
// wia_dpath
// Datapath: window length register, mark time, interval ring with per-entry
// valid bits, running sum, fill count, bit-serial divider and output stage.
// ----------------------------------------------------------------------------
module wia_dpath #(
  parameter int RingDepth = wia_pkg::RingDepthDef,
  localparam int SlotW = (RingDepth > 1) ? $clog2(RingDepth) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wia_pkg::cmd_t                 cmd_i,
  output wia_pkg::sts_t                 sts_o,
  input  logic [wia_pkg::OpW-1:0]       op_i,
  input  logic [wia_pkg::TimeW-1:0]     now_time_i,
  input  logic [wia_pkg::WinLenW-1:0]   window_len_i,
  output logic [wia_pkg::IntervalW-1:0] interval_o,
  output logic [wia_pkg::SumW-1:0]      window_sum_o,
  output logic [wia_pkg::FillW-1:0]     fill_count_o,
  output logic [wia_pkg::MeanW-1:0]     mean_interval_o
);

  logic [wia_pkg::WinLenW-1:0]   win_len_q;
  logic [wia_pkg::OpW-1:0]       op_q;
  logic [wia_pkg::TimeW-1:0]     now_q;
  logic [wia_pkg::TimeW-1:0]     mark_q;
  logic [wia_pkg::IntervalW-1:0] interval_q;
  logic [wia_pkg::SumW-1:0]      sum_q;
  logic [wia_pkg::FillW-1:0]     count_q;
  logic [wia_pkg::MeanW-1:0]     mean_q;
  logic [SlotW-1:0]              slot_q;
  logic [RingDepth-1:0]          valid_q;

  logic [wia_pkg::SumW-1:0]      quo_q;
  logic [wia_pkg::FillW-1:0]     rem_q;
  logic [wia_pkg::FillW-1:0]     divisor_q;
  logic [wia_pkg::DivCntW-1:0]   div_cnt_q;

  logic [wia_pkg::IntervalW-1:0] out_interval_q;
  logic [wia_pkg::SumW-1:0]      out_sum_q;
  logic [wia_pkg::FillW-1:0]     out_count_q;
  logic [wia_pkg::MeanW-1:0]     out_mean_q;

  logic [wia_pkg::FillW-1:0]     len_eff;
  logic [SlotW-1:0]              slot_eff;
  logic [SlotW:0]                slot_inc;
  logic [SlotW-1:0]              slot_next;
  logic [wia_pkg::TimeW-1:0]     diff;
  logic [wia_pkg::IntervalW-1:0] interval_sat;
  logic [wia_pkg::IntervalW-1:0] ring_rdata;
  logic [wia_pkg::IntervalW-1:0] old_val;
  logic [wia_pkg::SumW-1:0]      sum_new;
  logic [wia_pkg::FillW-1:0]     count_new;
  logic [wia_pkg::FillW:0]       div_shift;
  logic                          div_bit;
  logic [wia_pkg::FillW-1:0]     rem_next;
  logic [wia_pkg::SumW-1:0]      quo_next;
  logic                          is_record;
  logic                          clear_win;

  // Window length as used: zero acts as one, and it never exceeds the ring.
  always_comb begin
    if (win_len_q == '0) begin
      len_eff = wia_pkg::FillW'(1);
    end else if (int'(win_len_q) > RingDepth) begin
      len_eff = wia_pkg::FillW'(RingDepth);
    end else begin
      len_eff = win_len_q;
    end
  end

  always_comb begin
    slot_eff = (int'(slot_q) >= int'(len_eff)) ? '0 : slot_q;
    slot_inc = {1'b0, slot_eff} + (SlotW+1)'(1);
    slot_next = (int'(slot_inc) >= int'(len_eff)) ? '0 : slot_inc[SlotW-1:0];
  end

  assign diff         = now_q - mark_q;
  assign interval_sat = (diff[wia_pkg::TimeW-1:wia_pkg::IntervalW] != '0) ?
                        '1 : diff[wia_pkg::IntervalW-1:0];
  assign is_record    = (op_q == wia_pkg::OP_RECORD);
  assign clear_win    = cmd_i.cfg_write || (cmd_i.fetch && op_q == wia_pkg::OP_RESET);

  assign old_val   = valid_q[slot_eff] ? ring_rdata : '0;
  assign sum_new   = sum_q - {{(wia_pkg::SumW-wia_pkg::IntervalW){1'b0}}, old_val};
  assign count_new = (count_q < len_eff) ? count_q + wia_pkg::FillW'(1) : count_q;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // The remainder stays below the divisor, so it always fits the count width.
  always_comb begin
    div_shift = {rem_q, quo_q[wia_pkg::SumW-1]};
    div_bit   = (div_shift >= {1'b0, divisor_q});
    rem_next  = div_bit ? wia_pkg::FillW'(div_shift - {1'b0, divisor_q}) :
                          div_shift[wia_pkg::FillW-1:0];
    quo_next  = {quo_q[wia_pkg::SumW-2:0], div_bit};
  end

  assign sts_o.is_record = is_record;
  assign sts_o.div_last  = (div_cnt_q == '0);

  wia_ram #(
    .Width(wia_pkg::IntervalW),
    .Depth(RingDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(slot_eff),
    .wdata_i(interval_q),
    .re_i   (cmd_i.fetch && is_record),
    .raddr_i(slot_eff),
    .rdata_o(ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= wia_pkg::WinLenRst;
      mark_q    <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      mean_q    <= '0;
      slot_q    <= '0;
      valid_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.cfg_write) begin
        win_len_q <= window_len_i;
      end
      if (clear_win) begin
        sum_q   <= '0;
        count_q <= '0;
        slot_q  <= '0;
        valid_q <= '0;
      end
      if (cmd_i.fetch) begin
        if (is_record) begin
          sum_q <= sum_q + {{(wia_pkg::SumW-wia_pkg::IntervalW){1'b0}}, interval_sat};
        end else if (op_q == wia_pkg::OP_START || op_q == wia_pkg::OP_RESET) begin
          mark_q <= now_q;
        end
      end
      if (cmd_i.commit) begin
        sum_q             <= sum_new;
        count_q           <= count_new;
        slot_q            <= slot_next;
        valid_q[slot_eff] <= 1'b1;
        mark_q            <= now_q;
        div_cnt_q         <= wia_pkg::DivCntW'(wia_pkg::DivSteps - 1);
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - wia_pkg::DivCntW'(1);
        if (div_cnt_q == '0) begin
          mean_q <= (quo_next[wia_pkg::SumW-1:wia_pkg::MeanW] != '0) ?
                    '1 : quo_next[wia_pkg::MeanW-1:0];
        end
      end
    end
  end

  // Payload registers: captured beat, divider working set and output stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      now_q <= now_time_i;
    end
    if (cmd_i.fetch) begin
      interval_q <= is_record ? interval_sat : '0;
    end
    if (cmd_i.commit) begin
      quo_q     <= sum_new;
      rem_q     <= '0;
      divisor_q <= count_new;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_next;
      rem_q <= rem_next;
    end
    if (cmd_i.out_load) begin
      out_interval_q <= interval_q;
      out_sum_q      <= sum_q;
      out_count_q    <= count_q;
      out_mean_q     <= mean_q;
    end
  end

  assign interval_o      = out_interval_q;
  assign window_sum_o    = out_sum_q;
  assign fill_count_o    = out_count_q;
  assign mean_interval_o = out_mean_q;

endmodule

// File: hw/rtl/window_interval_average_top.sv
// A record beat passes through fetch, update and then 36 steps of the
// bit-serial divider, one quotient bit per cycle, before its result shows;
// start, reset and unused operations go from fetch to the output stage. The
// block takes a new beat only after the last result has gone to its output.
// Reset (rst_ni low, asynchronous) empties the window through per-entry valid
// bits, zeroes mark, sum, count and mean, and sets the window length to 16.
// ----------------------------------------------------------------------------
// window_interval_average_top
// Moving average of the intervals between timestamped events over a window
// of the most recent intervals, with a configurable window length.
// ----------------------------------------------------------------------------
module window_interval_average_top #(
  parameter int RingDepth = wia_pkg::RingDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Event beats: operation and the current time in microseconds.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wia_pkg::OpW-1:0]       op_i,
  input  logic [wia_pkg::TimeW-1:0]     now_time_i,
  // Window length register write.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wia_pkg::WinLenW-1:0]   window_len_i,
  // Result beats.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wia_pkg::IntervalW-1:0] interval_o,
  output logic [wia_pkg::SumW-1:0]      window_sum_o,
  output logic [wia_pkg::FillW-1:0]     fill_count_o,
  output logic [wia_pkg::MeanW-1:0]     mean_interval_o
);

  // The controller only sequences; every piece of state that the result
  // depends on lives in the datapath.
  wia_pkg::cmd_t cmd;
  wia_pkg::sts_t sts;

  // The controller accepts a beat only when idle, and a window length write
  // only then as well. A write also empties the window, so it is given
  // priority over a beat arriving in the same cycle.
  wia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath measures the interval, keeps the ring and the running sum,
  // and divides the sum by the fill count one quotient bit per cycle. Its
  // output stage holds a finished result while the next beat is taken.
  wia_dpath #(
    .RingDepth(RingDepth)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .now_time_i     (now_time_i),
    .window_len_i   (window_len_i),
    .interval_o     (interval_o),
    .window_sum_o   (window_sum_o),
    .fill_count_o   (fill_count_o),
    .mean_interval_o(mean_interval_o)
  );

endmodule

// File: hw/rtl/wia_chk.sv
// ----------------------------------------------------------------------------
// wia_chk
// Port-level checks of the window interval averager, bound to the top level.
// ----------------------------------------------------------------------------
module wia_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [wia_pkg::IntervalW-1:0] interval_o,
  input logic [wia_pkg::SumW-1:0]      window_sum_o,
  input logic [wia_pkg::FillW-1:0]     fill_count_o
);

  // A result beat is held until the consumer takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before acceptance");

  // A register write and an event beat are never taken at the same edge.
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o && in_valid_i && in_ready_o))
    else $error("config write and event beat accepted together");

  // An empty window always carries a zero sum.
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_count_o == '0 |-> window_sum_o == '0)
    else $error("nonzero sum reported for an empty window");

  // A nonzero interval comes only from a record, which leaves the window filled.
  a_record_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && interval_o != '0 |-> fill_count_o != '0)
    else $error("recorded interval with an empty window");

endmodule

bind window_interval_average_top wia_chk u_wia_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .interval_o  (interval_o),
  .window_sum_o(window_sum_o),
  .fill_count_o(fill_count_o)
);

// File: test/window_interval_average_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_interval_average_top_test
// Self-checking bench for the window interval averager. A driver feeds
// timestamped event beats through the valid/ready input with random gaps. A
// monitor checks every result beat, field by field, against a behavioral copy
// of the averaging window that the bench keeps itself. The run covers several
// window lengths, the out-of-range ones among them.
// ----------------------------------------------------------------------------
module window_interval_average_top_test;
  import wia_pkg::*;

  localparam int RingDepth      = RingDepthDef;
  localparam int IdlePct        = 26;     // chance in a hundred of an idle cycle
  localparam int StallLimit     = 2000;   // cycles with no beat at all
  localparam int RandomPerPhase = 75;
  localparam int NumPhases      = 10;
  localparam int SettleCycles   = 50;     // outlasts the processing of a record beat
  localparam int DrainCycles    = 4;

  // Code 3 is not decoded by the block; it must leave the window untouched.
  localparam logic [OpW-1:0]   OP_UNUSED = 2'd3;
  localparam logic [TimeW-1:0] MaxInterval = TimeW'(32'hFFFF_FFFF);

  typedef struct packed {
    logic              hold_for_drain;  // wait for all results before sending
    logic [OpW-1:0]    op;
    logic [TimeW-1:0]  now;
  } timestamp_beat_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval;
    logic [SumW-1:0]      window_sum;
    logic [FillW-1:0]     fill_count;
    logic [MeanW-1:0]     mean_interval;
  } averager_result_t;

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [OpW-1:0]       op_i;
  logic [TimeW-1:0]     now_time_i;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [WinLenW-1:0]   window_len_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [IntervalW-1:0] interval_o;
  logic [SumW-1:0]      window_sum_o;
  logic [FillW-1:0]     fill_count_o;
  logic [MeanW-1:0]     mean_interval_o;

  // The beat currently offered on the input channel.
  timestamp_beat_t presented = '0;
  assign op_i       = presented.op;
  assign now_time_i = presented.now;

  timestamp_beat_t  beats_to_send[$];
  averager_result_t expected_averages[$];

  logic             in_taken     = 1'b0;  // input beat accepted at the last rising edge
  logic             calm         = 1'b0;  // no idling on either side while set
  int unsigned      quiet_cycles = 0;
  int unsigned      error_count  = 0;
  logic [TimeW-1:0] stamp_cursor = '0;

  // Bench copy of the averager state and its window length register.
  logic [WinLenW-1:0]   avg_len;
  logic [TimeW-1:0]     last_stamp;
  logic [IntervalW-1:0] interval_hist[RingDepth];
  int unsigned          next_slot;
  logic [FillW-1:0]     held;
  logic [SumW-1:0]      hist_sum;
  logic [MeanW-1:0]     held_mean;

  window_interval_average_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .now_time_i     (now_time_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .window_len_i   (window_len_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .interval_o     (interval_o),
    .window_sum_o   (window_sum_o),
    .fill_count_o   (fill_count_o),
    .mean_interval_o(mean_interval_o)
  );

  always #5 clk_i = ~clk_i;

  // Printing stops after a couple of hundred lines so that a badly broken
  // block cannot flood the log; every mismatch is still counted.
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 200) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] seen,
                             input logic [63:0] wanted);
    if (seen !== wanted) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, wanted));
    end
  endtask

  // Empties the window: history, slot, count and sum. Mark and mean survive.
  task automatic clear_history();
    foreach (interval_hist[i]) interval_hist[i] = '0;
    next_slot = 0;
    held      = '0;
    hist_sum  = '0;
  endtask

  // Applies one accepted event beat to the bench copy of the window and
  // queues the result beat that the block must return for it.
  task automatic advance_averager(input logic [OpW-1:0] op, input logic [TimeW-1:0] now);
    logic [IntervalW-1:0] ivl;
    logic [TimeW-1:0]     diff;
    logic [SumW-1:0]      quot;
    int unsigned          span;
    int unsigned          slot;
    averager_result_t     res;
    ivl = '0;
    // A length of zero acts as one, anything past the ring depth as the depth.
    if (avg_len == 0) span = 1;
    else if (avg_len > RingDepth) span = RingDepth;
    else span = 32'(avg_len);
    case (op)
      OP_RECORD: begin
        // Time difference wraps at 48 bits, then saturates to 32 bits.
        diff = now - last_stamp;
        ivl  = (diff > MaxInterval) ? '1 : diff[IntervalW-1:0];
        slot = (next_slot >= span) ? 0 : next_slot;
        if (held < span) held = held + FillW'(1);
        hist_sum = hist_sum + SumW'(ivl) - SumW'(interval_hist[slot]);
        interval_hist[slot] = ivl;
        slot++;
        next_slot  = (slot >= span) ? 0 : slot;
        last_stamp = now;
        quot       = hist_sum / SumW'(held);
        held_mean  = (quot > SumW'(MaxInterval)) ? '1 : quot[MeanW-1:0];
      end
      OP_START: begin
        last_stamp = now;
      end
      OP_RESET: begin
        last_stamp = now;
        clear_history();
      end
      default: begin
      end
    endcase
    res.interval      = ivl;
    res.window_sum    = hist_sum;
    res.fill_count    = held;
    res.mean_interval = held_mean;
    expected_averages.push_back(res);
  endtask

  task automatic push_beat(input logic [OpW-1:0] op, input logic [TimeW-1:0] now,
                           input logic hold);
    timestamp_beat_t b;
    b.hold_for_drain = hold;
    b.op             = op;
    b.now            = now;
    beats_to_send.push_back(b);
  endtask

  // Mostly records at frame-like spacing, with starts, resets and unused codes
  // mixed in, plus steps near the 32-bit saturation point, arbitrary jumps
  // and steps backwards in time.
  task automatic push_random_beat();
    int unsigned      op_roll;
    int unsigned      gap_roll;
    logic [OpW-1:0]   op;
    logic [TimeW-1:0] delta;
    op_roll  = $urandom_range(99);
    gap_roll = $urandom_range(99);
    if (op_roll < 70) op = OP_RECORD;
    else if (op_roll < 82) op = OP_START;
    else if (op_roll < 93) op = OP_RESET;
    else op = OP_UNUSED;
    if (gap_roll < 55) delta = TimeW'($urandom_range(20000, 1000));
    else if (gap_roll < 65) delta = TimeW'($urandom_range(999));
    else if (gap_roll < 77) delta = TimeW'($urandom);
    else if (gap_roll < 85) delta = MaxInterval - TimeW'(1) + TimeW'($urandom_range(3));
    else if (gap_roll < 92) delta = TimeW'({$urandom, $urandom});
    else delta = -TimeW'($urandom_range(1000));
    stamp_cursor = stamp_cursor + delta;
    push_beat(op, stamp_cursor, $urandom_range(99) < 2);
  endtask

  // The block counts as idle once nothing is queued, offered or outstanding.
  task automatic wait_for_idle();
    while (beats_to_send.size() != 0 || in_valid_i || expected_averages.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window_len(input logic [WinLenW-1:0] len);
    @(negedge clk_i);
    cfg_valid_i  <= 1'b1;
    window_len_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Input driver and result back-pressure. Everything changes on the falling
  // edge, so the block always sees stable inputs at the rising edge. A beat
  // stays offered, unchanged, until the monitor has seen it accepted.
  always @(negedge clk_i) begin : beat_driver
    logic send;
    if (rst_ni) begin
      out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
      if (!in_valid_i || in_taken) begin
        send = (beats_to_send.size() != 0) && (calm || $urandom_range(99) >= IdlePct);
        // A marked beat holds back until every outstanding result has come.
        if (send && beats_to_send[0].hold_for_drain && expected_averages.size() != 0) begin
          send = 1'b0;
        end
        if (send) begin
          presented  <= beats_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats first, then applies a register write or an
  // accepted event beat to the bench copy. A result never leaves in the same
  // cycle as its own event beat is taken, so this order is safe.
  always @(posedge clk_i) begin : result_monitor
    averager_result_t want;
    logic             in_fire;
    logic             out_fire;
    logic             cfg_fire;
    if (rst_ni) begin
      in_fire  = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      cfg_fire = cfg_valid_i && cfg_ready_o;
      in_taken <= in_fire;
      if (out_fire) begin
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, interval %0h",
                                    interval_o));
        end else begin
          want = expected_averages.pop_front();
          check_field("interval", 64'(interval_o), 64'(want.interval));
          check_field("window_sum", 64'(window_sum_o), 64'(want.window_sum));
          check_field("fill_count", 64'(fill_count_o), 64'(want.fill_count));
          check_field("mean_interval", 64'(mean_interval_o), 64'(want.mean_interval));
        end
      end
      if (cfg_fire) begin
        // A length write also empties the window.
        avg_len = window_len_i;
        clear_history();
      end
      if (in_fire) begin
        advance_averager(presented.op, presented.now);
      end
      if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("window_interval_average_top test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [WinLenW-1:0] phase_len[NumPhases];
    logic [TimeW-1:0]   t;
    // Out-of-range lengths on both sides, the smallest and largest legal
    // ones, and a couple of random picks.
    phase_len = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd5, 5'd0, 5'd0, 5'd8};
    phase_len[7] = WinLenW'($urandom_range(31));
    phase_len[8] = WinLenW'($urandom_range(31));

    // State of the block right after reset.
    avg_len    = WinLenRst;
    last_stamp = '0;
    held_mean  = '0;
    clear_history();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, on the reset window length of 16.
    push_beat(OP_RECORD, 48'd0, 1'b0);             // zero interval from the reset mark
    push_beat(OP_START, 48'd1000, 1'b0);
    push_beat(OP_RECORD, 48'd17667, 1'b0);
    push_beat(OP_UNUSED, 48'd5, 1'b0);             // must not move the mark
    push_beat(OP_RECORD, 48'd17666, 1'b0);         // one step back: wraps and saturates
    push_beat(OP_START, '1, 1'b0);                 // mark at the top of the time range
    push_beat(OP_RECORD, 48'd4, 1'b0);             // wraps past zero to an interval of 5
    push_beat(OP_RESET, 48'd100, 1'b1);            // sent only once all results are back
    // Fill the whole ring with the largest interval that does not saturate,
    // driving the sum close to the top of its 36 bits.
    t = 48'd100;
    repeat (RingDepth) begin
      t = t + MaxInterval;
      push_beat(OP_RECORD, t, 1'b0);
    end
    stamp_cursor = t;

    for (int p = 0; p < NumPhases; p++) begin
      wait_for_idle();
      write_window_len(phase_len[p]);
      calm = (p == 6);
      repeat (RandomPerPhase) push_random_beat();
    end

    wait_for_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_averages.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_averages.size()));
    end
    if (error_count == 0) begin
      $display("window_interval_average_top test passed");
    end else begin
      $display("window_interval_average_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wia_pkg.sv
hw/rtl/wia_ram.sv
hw/rtl/wia_ctrl.sv
hw/rtl/wia_dpath.sv
hw/rtl/window_interval_average_top.sv
hw/rtl/wia_chk.sv
test/window_interval_average_top_test.sv
